// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the triangle tangent basis RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define TTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ----- hdl/ttb_pkg.sv -----
// Package: payload types, datapath commands and fixed-point widths.
`timescale 1ns / 1ps

package ttb_pkg;

    localparam int OUT_FRAC_BITS = 14;
    // raw tangent/binormal/determinant width (signed)
    localparam int CW = 59;
    // magnitude width of a raw component
    localparam int MW = 58;
    // divider numerator / shifted divisor width
    localparam int DW = 32 + OUT_FRAC_BITS;
    // quotient width, quotient never exceeds 2^OUT_FRAC_BITS
    localparam int QW = OUT_FRAC_BITS + 1;

    localparam logic [31:0] DET_EPS_RESET = 32'd429497;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic               uv_degenerate;
        logic               zero_vector;
    } basis_t;

    typedef enum logic [4:0] {
        OP_NONE       = 5'd0,
        OP_CORNER     = 5'd1,
        OP_TRI        = 5'd2,
        OP_MUL        = 5'd3,
        OP_MACC       = 5'd4,
        OP_DET        = 5'd5,
        OP_LOADV      = 5'd6,
        OP_NORM       = 5'd7,
        OP_SQ         = 5'd8,
        OP_SQACC      = 5'd9,
        OP_SQRT_INIT  = 5'd10,
        OP_SQRT       = 5'd11,
        OP_DIV_INIT   = 5'd12,
        OP_DIV        = 5'd13,
        OP_DIV_STORE  = 5'd14,
        OP_OUT        = 5'd15
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
        logic       vec;
    } cmd_t;

    typedef struct packed {
        logic norm_done;
        logic vec_zero;
    } status_t;

endpackage

// ----- hdl/triangle_tangent_basis_core.sv -----
// Top level: per-triangle tangent and binormal unit vectors from a vertex stream.
//
// vertex channel (valid/stall): one vertex per transaction; every three
// consecutive vertices form a triangle. basis channel (valid/stall): one
// transaction per triangle, tangent and binormal in Q1.14 plus two flags.
// det_eps_we/det_eps_wdata write the determinant threshold; write only while idle.
// Corners A and B are stored while the controller is idle. The third vertex starts the
// triangle; vertex_stall stays high until its result is in the output register.
// With both vectors nonzero, a triangle runs the 14 products on the shared
// 33x33 multiplier, the determinant test, then per vector a load, normalize
// shifts plus a check, the squares, the square-root steps and three divisions,
// and last the load of the result register. A zero-length vector ends after
// its load and the zero check.
// The result register lets the next triangle run while a result waits; a
// finished triangle holds in the controller until the old result is taken.
// Reset clears the corner count, the controller and basis_valid, and loads
// the threshold with 0.0001 in Q.32.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module triangle_tangent_basis_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             det_eps_we,
    input  logic [31:0]      det_eps_wdata,
    input  logic             vertex_valid,
    output logic             vertex_stall,
    input  ttb_pkg::vertex_t vertex,
    output logic             basis_valid,
    input  logic             basis_stall,
    output ttb_pkg::basis_t  basis
);
    import ttb_pkg::*;

    cmd_t    cmd;
    status_t status;

    ttb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .basis_valid  (basis_valid),
        .basis_stall  (basis_stall),
        .status       (status),
        .cmd          (cmd)
    );

    ttb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .det_eps_we    (det_eps_we),
        .det_eps_wdata (det_eps_wdata),
        .vertex        (vertex),
        .cmd           (cmd),
        .status        (status),
        .basis         (basis)
    );

    `TTB_ASSERT(a_accept_cmd, (vertex_valid && !vertex_stall) |-> (cmd.op == OP_CORNER || cmd.op == OP_TRI), "accepted vertex not stored")
    `TTB_ASSERT(a_tri_busy, (cmd.op == OP_TRI) |=> vertex_stall, "input open during triangle")
    `TTB_ASSERT(a_no_overwrite, (cmd.op == OP_OUT) |-> (!basis_valid || !basis_stall), "pending result overwritten")
    `TTB_ASSERT(a_result_busy, $rose(basis_valid) |-> $past(vertex_stall), "result without triangle")

endmodule

// ----- hdl/ttb_datapath.sv -----
// Datapath: corner storage, shared multiplier, normalizer, square root and divider.
`timescale 1ns / 1ps

module ttb_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             det_eps_we,
    input  logic [31:0]      det_eps_wdata,
    input  ttb_pkg::vertex_t vertex,
    input  ttb_pkg::cmd_t    cmd,
    output ttb_pkg::status_t status,
    output ttb_pkg::basis_t  basis
);
    import ttb_pkg::*;

    logic [31:0]           eps_reg;
    vertex_t               a_reg, b_reg;
    logic signed [32:0]    e1_reg [3];
    logic signed [32:0]    e2_reg [3];
    logic signed [24:0]    d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [63:0]    prod_reg;
    logic signed [CW-1:0]  acc_reg;
    logic signed [CW-1:0]  res_reg [7];
    logic                  degen_reg, neg_reg;
    logic [MW-1:0]         m_reg [3];
    logic [MW-1:0]         mx_reg;
    logic                  sgn_reg [3];
    logic                  zero_reg, zt_reg, zb_reg;
    logic [63:0]           sum_reg, srem_reg, sres_reg, sbit_reg;
    logic [DW-1:0]         drem_reg, dsr_reg;
    logic [QW-1:0]         q_reg;
    logic signed [15:0]    tu_reg [3];
    logic signed [15:0]    bu_reg [3];
    basis_t                basis_reg;

    logic signed [32:0]    mul_a, mul_b;
    logic signed [65:0]    mul_p;
    logic [MW-1:0]         m_sel;
    logic                  sgn_sel;
    logic signed [CW-1:0]  c_in [3];
    logic [MW-1:0]         mag [3];
    logic [MW-1:0]         mx01, mx_all;
    logic [CW-1:0]         adet;
    logic [63:0]           sq_try;
    logic [31:0]           len;
    logic signed [63:0]    q_ext, q_signed;

    assign len = sres_reg[31:0];

    always_comb
    begin
        unique case (cmd.idx[1:0])
            2'd1:    begin m_sel = m_reg[1]; sgn_sel = sgn_reg[1]; end
            2'd2:    begin m_sel = m_reg[2]; sgn_sel = sgn_reg[2]; end
            default: begin m_sel = m_reg[0]; sgn_sel = sgn_reg[0]; end
        endcase
    end

    // multiplier operand select: products pair up as first minus second
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == OP_SQ)
        begin
            mul_a = $signed({2'b00, m_sel[30:0]});
            mul_b = $signed({2'b00, m_sel[30:0]});
        end
        else if (cmd.op == OP_MUL)
        begin
            unique case (cmd.idx[3:1])
                3'd0:
                begin
                    mul_a = cmd.idx[0] ? 33'(d1v_reg) : 33'(d1u_reg);
                    mul_b = cmd.idx[0] ? 33'(d2u_reg) : 33'(d2v_reg);
                end
                3'd1:
                begin
                    mul_a = cmd.idx[0] ? e2_reg[0] : e1_reg[0];
                    mul_b = cmd.idx[0] ? 33'(d1v_reg) : 33'(d2v_reg);
                end
                3'd2:
                begin
                    mul_a = cmd.idx[0] ? e2_reg[1] : e1_reg[1];
                    mul_b = cmd.idx[0] ? 33'(d1v_reg) : 33'(d2v_reg);
                end
                3'd3:
                begin
                    mul_a = cmd.idx[0] ? e2_reg[2] : e1_reg[2];
                    mul_b = cmd.idx[0] ? 33'(d1v_reg) : 33'(d2v_reg);
                end
                3'd4:
                begin
                    mul_a = cmd.idx[0] ? e1_reg[0] : e2_reg[0];
                    mul_b = cmd.idx[0] ? 33'(d2u_reg) : 33'(d1u_reg);
                end
                3'd5:
                begin
                    mul_a = cmd.idx[0] ? e1_reg[1] : e2_reg[1];
                    mul_b = cmd.idx[0] ? 33'(d2u_reg) : 33'(d1u_reg);
                end
                3'd6:
                begin
                    mul_a = cmd.idx[0] ? e1_reg[2] : e2_reg[2];
                    mul_b = cmd.idx[0] ? 33'(d2u_reg) : 33'(d1u_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_in[i] = cmd.vec ? res_reg[4 + i] : res_reg[1 + i];
            mag[i]  = c_in[i][CW-1] ? MW'(-c_in[i]) : MW'(c_in[i]);
        end
        mx01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
        mx_all = (mx01 > mag[2]) ? mx01 : mag[2];
    end

    assign adet   = res_reg[0][CW-1] ? -res_reg[0] : res_reg[0];
    assign sq_try = sres_reg + sbit_reg;

    assign q_ext    = $signed(64'(q_reg));
    assign q_signed = (sgn_sel ^ neg_reg) ? -q_ext : q_ext;

    assign status.vec_zero  = zero_reg;
    assign status.norm_done = (mx_reg[MW-1:31] == '0) && mx_reg[30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= DET_EPS_RESET;
        else if (det_eps_we)
            eps_reg <= det_eps_wdata;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CORNER:
            begin
                if (cmd.idx[0])
                    b_reg <= vertex;
                else
                    a_reg <= vertex;
            end
            OP_TRI:
            begin
                e1_reg[0] <= {b_reg.pos_x[31], b_reg.pos_x} - {a_reg.pos_x[31], a_reg.pos_x};
                e1_reg[1] <= {b_reg.pos_y[31], b_reg.pos_y} - {a_reg.pos_y[31], a_reg.pos_y};
                e1_reg[2] <= {b_reg.pos_z[31], b_reg.pos_z} - {a_reg.pos_z[31], a_reg.pos_z};
                e2_reg[0] <= {vertex.pos_x[31], vertex.pos_x} - {a_reg.pos_x[31], a_reg.pos_x};
                e2_reg[1] <= {vertex.pos_y[31], vertex.pos_y} - {a_reg.pos_y[31], a_reg.pos_y};
                e2_reg[2] <= {vertex.pos_z[31], vertex.pos_z} - {a_reg.pos_z[31], a_reg.pos_z};
                d1u_reg <= {b_reg.tex_u[23], b_reg.tex_u} - {a_reg.tex_u[23], a_reg.tex_u};
                d1v_reg <= {b_reg.tex_v[23], b_reg.tex_v} - {a_reg.tex_v[23], a_reg.tex_v};
                d2u_reg <= {vertex.tex_u[23], vertex.tex_u} - {a_reg.tex_u[23], a_reg.tex_u};
                d2v_reg <= {vertex.tex_v[23], vertex.tex_v} - {a_reg.tex_v[23], a_reg.tex_v};
            end
            OP_MUL, OP_SQ:
                prod_reg <= mul_p[63:0];
            OP_MACC:
            begin
                if (!cmd.idx[0])
                    acc_reg <= prod_reg[CW-1:0];
                else
                    res_reg[cmd.idx[3:1]] <= acc_reg - prod_reg[CW-1:0];
            end
            OP_DET:
            begin
                degen_reg <= adet < CW'(eps_reg);
                neg_reg   <= !(adet < CW'(eps_reg)) && res_reg[0][CW-1];
            end
            OP_LOADV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i]   <= mag[i];
                    sgn_reg[i] <= c_in[i][CW-1];
                    if (cmd.vec)
                        bu_reg[i] <= '0;
                    else
                        tu_reg[i] <= '0;
                end
                mx_reg   <= mx_all;
                zero_reg <= (mx_all == '0);
                sum_reg  <= '0;
                if (cmd.vec)
                    zb_reg <= (mx_all == '0);
                else
                    zt_reg <= (mx_all == '0);
            end
            OP_NORM:
            begin
                // one bit a cycle toward [2^30, 2^31); right shifts truncate
                if (mx_reg[MW-1:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= m_reg[i] >> 1;
                    mx_reg <= mx_reg >> 1;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= m_reg[i] << 1;
                    mx_reg <= mx_reg << 1;
                end
            end
            OP_SQACC:
                sum_reg <= sum_reg + 64'(prod_reg);
            OP_SQRT_INIT:
            begin
                srem_reg <= sum_reg;
                sres_reg <= '0;
                sbit_reg <= 64'd1 << 62;
            end
            OP_SQRT:
            begin
                if (srem_reg >= sq_try)
                begin
                    srem_reg <= srem_reg - sq_try;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                    sres_reg <= sres_reg >> 1;
                sbit_reg <= sbit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                drem_reg <= (DW'(m_sel[30:0]) << OUT_FRAC_BITS) + DW'(len[31:1]);
                dsr_reg  <= DW'(len) << OUT_FRAC_BITS;
                q_reg    <= '0;
            end
            OP_DIV:
            begin
                if (drem_reg >= dsr_reg)
                begin
                    drem_reg <= drem_reg - dsr_reg;
                    q_reg    <= {q_reg[QW-2:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                dsr_reg <= dsr_reg >> 1;
            end
            OP_DIV_STORE:
            begin
                if (cmd.vec)
                    bu_reg[cmd.idx[1:0]] <= q_signed[15:0];
                else
                    tu_reg[cmd.idx[1:0]] <= q_signed[15:0];
            end
            OP_OUT:
            begin
                basis_reg.tangent_x     <= tu_reg[0];
                basis_reg.tangent_y     <= tu_reg[1];
                basis_reg.tangent_z     <= tu_reg[2];
                basis_reg.binormal_x    <= bu_reg[0];
                basis_reg.binormal_y    <= bu_reg[1];
                basis_reg.binormal_z    <= bu_reg[2];
                basis_reg.uv_degenerate <= degen_reg;
                basis_reg.zero_vector   <= zt_reg | zb_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign basis = basis_reg;

endmodule

// ----- hdl/ttb_ctrl.sv -----
// Controller: corner sequencing, triangle schedule and result handshake.
`timescale 1ns / 1ps

module ttb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vertex_valid,
    output logic             vertex_stall,
    output logic             basis_valid,
    input  logic             basis_stall,
    input  ttb_pkg::status_t status,
    output ttb_pkg::cmd_t    cmd
);
    import ttb_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_MUL   = 12'b000000000010,
        S_DET   = 12'b000000000100,
        S_LOADV = 12'b000000001000,
        S_NORM  = 12'b000000010000,
        S_SQ    = 12'b000000100000,
        S_SQI   = 12'b000001000000,
        S_SQRT  = 12'b000010000000,
        S_DIVI  = 12'b000100000000,
        S_DIVS  = 12'b001000000000,
        S_DIVW  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    localparam logic [5:0] MUL_LAST  = 6'd27;
    localparam logic [5:0] SQ_LAST   = 6'd5;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'(OUT_FRAC_BITS);

    state_t      state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  sub_reg, sub_next;
    logic        vec_reg, vec_next;
    logic        valid_reg, valid_next;
    logic        vec_done;

    assign vertex_stall = (state_reg != S_IDLE);
    assign basis_valid  = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg + 6'd1;
        sub_next   = sub_reg;
        vec_next   = vec_reg;
        valid_next = valid_reg && basis_stall;
        vec_done   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = '0;
        cmd.vec    = vec_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (vertex_valid)
                begin
                    if (phase_reg == 2'd2)
                    begin
                        cmd.op     = OP_TRI;
                        phase_next = 2'd0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        // stray phase value three restarts at corner A
                        cmd.op     = OP_CORNER;
                        cmd.idx    = {3'b000, phase_reg == 2'd1};
                        phase_next = (phase_reg == 2'd1) ? 2'd2 : 2'd1;
                    end
                end
            end
            S_MUL:
            begin
                cmd.op  = cnt_reg[0] ? OP_MACC : OP_MUL;
                cmd.idx = cnt_reg[4:1];
                if (cnt_reg == MUL_LAST)
                    state_next = S_DET;
            end
            S_DET:
            begin
                cmd.op     = OP_DET;
                vec_next   = 1'b0;
                state_next = S_LOADV;
            end
            S_LOADV:
            begin
                cmd.op     = OP_LOADV;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cnt_next = '0;
                priority if (status.vec_zero)
                    vec_done = 1'b1;
                else if (status.norm_done)
                    state_next = S_SQ;
                else
                    cmd.op = OP_NORM;
            end
            S_SQ:
            begin
                cmd.op  = cnt_reg[0] ? OP_SQACC : OP_SQ;
                cmd.idx = {2'b00, cnt_reg[2:1]};
                if (cnt_reg == SQ_LAST)
                    state_next = S_SQI;
            end
            S_SQI:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    sub_next   = 2'd0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                cmd.op     = OP_DIV_INIT;
                cmd.idx    = {2'b00, sub_reg};
                cnt_next   = '0;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == DIV_LAST)
                    state_next = S_DIVW;
            end
            S_DIVW:
            begin
                cmd.op  = OP_DIV_STORE;
                cmd.idx = {2'b00, sub_reg};
                if (sub_reg == 2'd2)
                    vec_done = 1'b1;
                else
                begin
                    sub_next   = sub_reg + 2'd1;
                    state_next = S_DIVI;
                end
            end
            S_OUT:
            begin
                if (!valid_reg || !basis_stall)
                begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (vec_done)
        begin
            if (vec_reg)
                state_next = S_OUT;
            else
            begin
                vec_next   = 1'b1;
                state_next = S_LOADV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 2'd0;
            cnt_reg   <= '0;
            sub_reg   <= '0;
            vec_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            vec_reg   <= vec_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- bench/triangle_tangent_basis_core_test.sv -----
// Self-checking testbench for the triangle tangent basis core.
`timescale 1ns / 1ps

module triangle_tangent_basis_core_test;
    import ttb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        det_eps_we = 1'b0;
    logic [31:0] det_eps_wdata = '0;
    logic        vertex_valid = 1'b0;
    logic        vertex_stall;
    vertex_t     vertex = '0;
    logic        basis_valid;
    logic        basis_stall = 1'b0;
    basis_t      basis;

    triangle_tangent_basis_core uut (
        .clk(clk), .rst_n(rst_n),
        .det_eps_we(det_eps_we), .det_eps_wdata(det_eps_wdata),
        .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
        .basis_valid(basis_valid), .basis_stall(basis_stall), .basis(basis)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [31:0] eps_model;
    vertex_t     corner_a, corner_b;
    int          corner_cnt;
    basis_t      basis_q[$];

    int errors = 0;
    int triangles_seen = 0;
    int vertices_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;

    function automatic void unit_vector(input logic signed [63:0] c[3], input bit neg,
                                        output logic signed [15:0] r[3], output bit is_zero);
        logic [63:0] m[3];
        logic [63:0] mx, sum, len, rem, bitv, q;
        int n;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
        end
        is_zero = (mx == 0);
        if (is_zero)
        begin
            for (int i = 0; i < 3; i++) r[i] = '0;
            return;
        end
        n = 0;
        while (n < 64 && (mx >> n) != 0) n++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (n > 31) m[i] = m[i] >> (n - 31);
            else m[i] = m[i] << (31 - n);
            sum += m[i] * m[i];
        end
        // integer square root, bit by bit
        rem = sum; len = 0; bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= len + bitv)
            begin
                rem -= len + bitv;
                len = (len >> 1) + bitv;
            end
            else len >>= 1;
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
            r[i] = ((c[i] < 0) != neg) ? -q[15:0] : q[15:0];
        end
    endfunction

    function automatic void predict_vertex(input vertex_t v);
        logic signed [63:0] e1[3], e2[3], t[3], b[3];
        logic signed [63:0] d1u, d1v, d2u, d2v, det, adet;
        logic signed [15:0] tr[3], br[3];
        bit degen, neg, zt, zb;
        basis_t r;
        if (corner_cnt != 2)
        begin
            if (corner_cnt == 1) corner_b = v; else corner_a = v;
            corner_cnt = (corner_cnt == 1) ? 2 : 1;
            return;
        end
        corner_cnt = 0;
        e1[0] = 64'(corner_b.pos_x) - 64'(corner_a.pos_x);
        e1[1] = 64'(corner_b.pos_y) - 64'(corner_a.pos_y);
        e1[2] = 64'(corner_b.pos_z) - 64'(corner_a.pos_z);
        e2[0] = 64'(v.pos_x) - 64'(corner_a.pos_x);
        e2[1] = 64'(v.pos_y) - 64'(corner_a.pos_y);
        e2[2] = 64'(v.pos_z) - 64'(corner_a.pos_z);
        d1u = 64'(corner_b.tex_u) - 64'(corner_a.tex_u);
        d1v = 64'(corner_b.tex_v) - 64'(corner_a.tex_v);
        d2u = 64'(v.tex_u) - 64'(corner_a.tex_u);
        d2v = 64'(v.tex_v) - 64'(corner_a.tex_v);
        det = d1u * d2v - d1v * d2u;
        adet = det < 0 ? -det : det;
        degen = adet < $signed({32'd0, eps_model});
        neg = !degen && det < 0;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = e1[i] * d2v - e2[i] * d1v;
            b[i] = e2[i] * d1u - e1[i] * d2u;
        end
        unit_vector(t, neg, tr, zt);
        unit_vector(b, neg, br, zb);
        r.tangent_x = tr[0]; r.tangent_y = tr[1]; r.tangent_z = tr[2];
        r.binormal_x = br[0]; r.binormal_y = br[1]; r.binormal_z = br[2];
        r.uv_degenerate = degen;
        r.zero_vector = zt || zb;
        basis_q.insert(basis_q.size(), r);
    endfunction

    // valid stays up into the next call; idle cycles and pauses drop it
    task automatic send_vertex(input vertex_t v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(negedge clk);
        end
        vertex <= v;
        vertex_valid <= 1'b1;
        do @(posedge clk); while (vertex_stall);
        predict_vertex(v);
        vertices_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        vertex_valid <= 1'b0;
        while (basis_q.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_eps(input logic [31:0] val);
        wait_drained();
        det_eps_wdata <= val;
        det_eps_we <= 1'b1;
        @(negedge clk);
        det_eps_we <= 1'b0;
        eps_model = val;
    endtask

    function automatic vertex_t rand_vertex(input int mode);
        vertex_t v;
        v.pos_x = $urandom; v.pos_y = $urandom; v.pos_z = $urandom;
        v.tex_u = 24'($urandom); v.tex_v = 24'($urandom);
        if (mode == 1)
        begin
            // small mesh-like coordinates
            v.pos_x = $signed($urandom_range(8191)) - 4096 << $urandom_range(16);
            v.pos_y = $signed($urandom_range(8191)) - 4096 << $urandom_range(16);
            v.pos_z = $signed($urandom_range(8191)) - 4096 << $urandom_range(16);
            v.tex_u = 24'($signed($urandom_range(131071)) - 65536);
            v.tex_v = 24'($signed($urandom_range(131071)) - 65536);
        end
        return v;
    endfunction

    function automatic vertex_t mk(input int x, y, z, u, w);
        vertex_t v;
        v.pos_x = x; v.pos_y = y; v.pos_z = z; v.tex_u = 24'(u); v.tex_v = 24'(w);
        return v;
    endfunction

    task automatic test_directed();
        // well-formed right triangle
        send_vertex(mk(0, 0, 0, 0, 0));
        send_vertex(mk(32'h10000, 0, 0, 24'h10000, 0));
        send_vertex(mk(0, 32'h10000, 0, 0, 24'h10000));
        // mirrored UVs: negative determinant
        send_vertex(mk(0, 0, 0, 0, 0));
        send_vertex(mk(32'h10000, 0, 0, 0, 24'h10000));
        send_vertex(mk(0, 32'h10000, 0, 24'h10000, 0));
        // identical UVs: degenerate determinant
        send_vertex(mk(5, 6, 7, 24'h123, 24'h456));
        send_vertex(mk(32'h20000, 9, 1, 24'h123, 24'h456));
        send_vertex(mk(3, 32'h30000, 2, 24'h123, 24'h456));
        // identical positions: both vectors zero
        send_vertex(mk(1, 1, 1, 0, 0));
        send_vertex(mk(1, 1, 1, 24'h10000, 0));
        send_vertex(mk(1, 1, 1, 0, 24'h10000));
        // position and UV extremes
        send_vertex(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 24'h800000, 24'h7fffff));
        send_vertex(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'h7fffff, 24'h800000));
        send_vertex(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 24'h7fffff, 24'h7fffff));
        send_vertex(mk(32'hffffffff, 0, 32'h7fffffff, 24'hffffff, 0));
        send_vertex(mk(0, 32'hffffffff, 32'h80000000, 0, 24'hffffff));
        send_vertex(mk(32'h7fffffff, 32'h7fffffff, 0, 24'h800000, 24'h800000));
    endtask

    task automatic test_eps_extremes();
        // zero threshold: a zero determinant is not degenerate
        write_eps(32'd0);
        send_vertex(mk(0, 0, 0, 24'h10, 24'h10));
        send_vertex(mk(32'h10000, 0, 0, 24'h10, 24'h10));
        send_vertex(mk(0, 32'h10000, 0, 24'h10, 24'h10));
        for (int i = 0; i < 30; i++) send_vertex(rand_vertex(1));
        write_eps(32'hffffffff);
        for (int i = 0; i < 30; i++) send_vertex(rand_vertex(i % 2));
        write_eps(32'd1);
        for (int i = 0; i < 30; i++) send_vertex(rand_vertex(1));
        write_eps(DET_EPS_RESET);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_vertex(rand_vertex($urandom_range(3) == 0 ? 0 : 1));
    endtask

    task automatic test_backpressure();
        // hold the result side long enough for the core to fill up
        recv_hold = 1'b1;
        for (int i = 0; i < 12; i++) send_vertex(rand_vertex(1));
        // sender pauses until everything has drained
        wait_drained();
    endtask

    // long receiver hold-off, counted in its own process
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (recv_hold)
            begin
                basis_stall <= 1'b1;
                repeat (1500) @(negedge clk);
                recv_hold = 1'b0;
            end
            basis_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && basis_valid && !basis_stall)
        begin
            basis_t exp_r;
            triangles_seen++;
            if (basis_q.size() == 0)
            begin
                $error("unexpected basis transaction %p", basis);
                errors++;
            end
            else
            begin
                exp_r = basis_q.pop_front();
                if (basis.tangent_x !== exp_r.tangent_x)
                begin
                    $error("tangent_x exp %0d got %0d", exp_r.tangent_x, basis.tangent_x);
                    errors++;
                end
                if (basis.tangent_y !== exp_r.tangent_y)
                begin
                    $error("tangent_y exp %0d got %0d", exp_r.tangent_y, basis.tangent_y);
                    errors++;
                end
                if (basis.tangent_z !== exp_r.tangent_z)
                begin
                    $error("tangent_z exp %0d got %0d", exp_r.tangent_z, basis.tangent_z);
                    errors++;
                end
                if (basis.binormal_x !== exp_r.binormal_x)
                begin
                    $error("binormal_x exp %0d got %0d", exp_r.binormal_x, basis.binormal_x);
                    errors++;
                end
                if (basis.binormal_y !== exp_r.binormal_y)
                begin
                    $error("binormal_y exp %0d got %0d", exp_r.binormal_y, basis.binormal_y);
                    errors++;
                end
                if (basis.binormal_z !== exp_r.binormal_z)
                begin
                    $error("binormal_z exp %0d got %0d", exp_r.binormal_z, basis.binormal_z);
                    errors++;
                end
                if (basis.uv_degenerate !== exp_r.uv_degenerate)
                begin
                    $error("uv_degenerate exp %0b got %0b",
                           exp_r.uv_degenerate, basis.uv_degenerate);
                    errors++;
                end
                if (basis.zero_vector !== exp_r.zero_vector)
                begin
                    $error("zero_vector exp %0b got %0b", exp_r.zero_vector, basis.zero_vector);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        eps_model = DET_EPS_RESET;
        corner_cnt = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_eps_extremes();
        send_idle_pct = 19; recv_idle_pct = 71;
        test_random(108);
        send_idle_pct = 71; recv_idle_pct = 19;
        test_random(108);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(108);
        test_backpressure();
        wait_drained();
        $display("covered %0d vertices, %0d triangles checked, threshold zero/max/one/reset",
                 vertices_sent, triangles_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // time limit for the slowest run, stalls and hold-offs included
    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
